// ===== rtl/pshst_pkg.sv =====
`default_nettype none
package pshst_pkg;

    localparam int TABLE_ENTRIES = 20;
    localparam int IDX_W         = 5;
    localparam int GRAN_SHIFT    = 4;
    localparam int BASE_W        = 32 - GRAN_SHIFT;
    localparam int RATIO_SHIFT   = 10;
    localparam int RATIO_W       = 11;
    localparam int DIVIDEND_W    = 32 + RATIO_SHIFT;
    localparam int DIV_CNT_W     = 6;
    localparam logic [31:0] HIT_INC   = 32'd100;
    localparam logic [31:0] GRAN_BYTES = 32'd16;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 11'd1024;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic CFG_PRESCALE = 1'b0;
    localparam logic CFG_IGNORE   = 1'b1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [31:0]      sample_pc;
        logic [IDX_W-1:0] entry_index;
    } req_t;

    typedef struct packed {
        logic               sampled;
        logic               ignored;
        logic [IDX_W-1:0]   slot;
        logic [31:0]        entry_base;
        logic [31:0]        entry_hits;
        logic [RATIO_W-1:0] entry_ratio;
        logic [31:0]        total_hits;
        logic [31:0]        tick_count;
    } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/pc_sample_hot_spot_table_core.sv =====
// Sampling profiler with a 20-entry hot-spot table.
// Input words arrive on s_valid/s_ready/s_data: a timer tick with a PC,
// a read of one table entry, or a clear of the table. Every word gives one
// result word on m_valid/m_ready/m_data.
// Configuration is written through cfg_we/cfg_index/cfg_wdata with no wait:
// index 0 is the prescale divisor, index 1 the base of the ignore window.
// Reads, clears, ignored samples and ticks stopped by the prescaler are
// answered straight from the idle state. A profiled sample runs a
// sequencer: a decay step, a table search, an update step, the
// one-bit-per-cycle ratio divider and a bubble-up toward slot 0.
// One word is worked on at a time; s_ready is low while a word is in work
// or while its result waits in the output register for m_ready.
// Reset (aresetn low, synchronous) empties the table, zeroes counters and
// restores the divisor to 10 and the ignore base to 0.
`default_nettype none
module pc_sample_hot_spot_table_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pshst_pkg::req_t    s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pshst_pkg::rsp_t         m_data,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_wdata
);
    import pshst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECAY, ST_SEARCH, ST_HIT, ST_DIV, ST_BUBBLE
    } state_t;

    state_t state_reg;
    logic [7:0]  div_cfg_reg;
    logic [31:0] ign_reg;
    logic [7:0]  pre_reg;
    logic [31:0] tick_reg;
    logic [IDX_W-1:0] decay_reg;
    logic [31:0] total_reg;

    logic [BASE_W-1:0]  base_mem  [TABLE_ENTRIES];
    logic [31:0]        hits_mem  [TABLE_ENTRIES];
    logic [RATIO_W-1:0] ratio_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [BASE_W-1:0]  key_reg;
    logic [31:0]        cur_hits_reg;
    logic [RATIO_W-1:0] cur_ratio_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   free_reg;
    logic               free_ok_reg;
    logic               evict_reg;

    logic    m_valid_reg;
    rsp_t    rsp_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   rd_idx;
    logic [BASE_W-1:0]  rd_base;
    logic [31:0]        rd_hits;
    logic [RATIO_W-1:0] rd_ratio;

    logic [7:0]  pre_inc;
    logic [31:0] pc_off;
    logic [31:0] hits_new;
    logic [31:0] total_new;
    logic        div_done;
    logic [DIVIDEND_W-1:0] quo;
    logic        accept;

    rsp_t        idle_rsp;
    logic [7:0]  pre_next;
    logic        sample_hit;
    logic        profile_go;

    always_comb begin
        unique case (state_reg)
            ST_DECAY:  rd_addr = decay_reg;
            ST_SEARCH: rd_addr = ptr_reg;
            ST_HIT:    rd_addr = pos_reg;
            ST_BUBBLE: rd_addr = pos_reg - 1'b1;
            default:   rd_addr = s_data.entry_index;
        endcase
    end

    assign rd_idx   = (rd_addr < IDX_W'(TABLE_ENTRIES)) ? rd_addr : '0;
    assign rd_base  = valid_reg[rd_idx] ? base_mem[rd_idx]  : '0;
    assign rd_hits  = valid_reg[rd_idx] ? hits_mem[rd_idx]  : '0;
    assign rd_ratio = valid_reg[rd_idx] ? ratio_mem[rd_idx] : '0;

    assign pre_inc   = pre_reg + 8'd1;
    assign pc_off    = s_data.sample_pc - ign_reg;
    assign hits_new  = (evict_reg ? 32'd0 : rd_hits) + HIT_INC;
    assign total_new = total_reg - (evict_reg ? rd_hits : 32'd0) + HIT_INC;
    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;

    always_comb begin
        idle_rsp            = '0;
        idle_rsp.total_hits = total_reg;
        idle_rsp.tick_count = tick_reg;
        pre_next            = pre_reg;
        sample_hit          = 1'b0;
        profile_go          = 1'b0;
        unique case (s_data.req_type)
            REQ_TICK: begin
                pre_next = pre_inc;
                if (pre_inc >= div_cfg_reg) begin
                    pre_next            = '0;
                    sample_hit          = 1'b1;
                    idle_rsp.sampled    = 1'b1;
                    idle_rsp.tick_count = tick_reg + 32'd1;
                    if (pc_off < GRAN_BYTES) begin
                        idle_rsp.ignored = 1'b1;
                    end else begin
                        profile_go = 1'b1;
                    end
                end
            end
            REQ_READ: begin
                idle_rsp.slot = s_data.entry_index;
                if (s_data.entry_index < IDX_W'(TABLE_ENTRIES)) begin
                    idle_rsp.entry_base  = {rd_base, {GRAN_SHIFT{1'b0}}};
                    idle_rsp.entry_hits  = rd_hits;
                    idle_rsp.entry_ratio = rd_ratio;
                end
            end
            REQ_CLEAR: begin
                idle_rsp.total_hits = '0;
            end
            default: ;
        endcase
    end

    pshst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_HIT),
        .hits     (hits_new),
        .divisor  (total_new),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cfg_reg <= 8'd10;
            ign_reg     <= '0;
            pre_reg     <= '0;
            tick_reg    <= '0;
            decay_reg   <= '0;
            total_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PRESCALE: div_cfg_reg <= cfg_wdata[7:0];
                    CFG_IGNORE:   ign_reg     <= cfg_wdata;
                    default:      ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        rsp_reg <= idle_rsp;
                        pre_reg <= pre_next;
                        if (sample_hit) begin
                            tick_reg <= tick_reg + 32'd1;
                        end
                        if (profile_go) begin
                            key_reg   <= s_data.sample_pc[31:GRAN_SHIFT];
                            state_reg <= ST_DECAY;
                        end else begin
                            m_valid_reg <= 1'b1;
                        end
                        if (s_data.req_type == REQ_CLEAR) begin
                            valid_reg <= '0;
                            decay_reg <= '0;
                            total_reg <= '0;
                        end
                    end
                end
                ST_DECAY: begin
                    if (rd_hits > 32'd1) begin
                        hits_mem[rd_idx]  <= rd_hits - 32'd1;
                        base_mem[rd_idx]  <= rd_base;
                        ratio_mem[rd_idx] <= rd_ratio;
                        total_reg <= total_reg - 32'd1;
                    end
                    decay_reg   <= (decay_reg == IDX_W'(TABLE_ENTRIES - 1)) ?
                                   '0 : decay_reg + 1'b1;
                    ptr_reg     <= '0;
                    free_ok_reg <= 1'b0;
                    state_reg   <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (rd_base == key_reg) begin
                        pos_reg   <= ptr_reg;
                        evict_reg <= 1'b0;
                        state_reg <= ST_HIT;
                    end else begin
                        if (!free_ok_reg && rd_hits == 32'd0) begin
                            free_ok_reg <= 1'b1;
                            free_reg    <= ptr_reg;
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                        if (ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                            state_reg <= ST_HIT;
                            if (!free_ok_reg && rd_hits != 32'd0) begin
                                pos_reg   <= IDX_W'(TABLE_ENTRIES - 1);
                                evict_reg <= 1'b1;
                            end else begin
                                pos_reg   <= free_ok_reg ? free_reg : ptr_reg;
                                evict_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_HIT: begin
                    cur_hits_reg <= hits_new;
                    total_reg    <= total_new;
                    state_reg    <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        cur_ratio_reg <= (quo > DIVIDEND_W'(RATIO_MAX) || total_reg == '0) ?
                                         RATIO_MAX : quo[RATIO_W-1:0];
                        state_reg <= ST_BUBBLE;
                    end
                end
                ST_BUBBLE: begin
                    if (pos_reg != '0 && cur_hits_reg > rd_hits) begin
                        base_mem[pos_reg]  <= rd_base;
                        hits_mem[pos_reg]  <= rd_hits;
                        ratio_mem[pos_reg] <= rd_ratio;
                        valid_reg[pos_reg] <= 1'b1;
                        pos_reg <= pos_reg - 1'b1;
                    end else begin
                        base_mem[pos_reg]  <= key_reg;
                        hits_mem[pos_reg]  <= cur_hits_reg;
                        ratio_mem[pos_reg] <= cur_ratio_reg;
                        valid_reg[pos_reg] <= 1'b1;
                        rsp_reg     <= {1'b1, 1'b0, pos_reg,
                                        {key_reg, {GRAN_SHIFT{1'b0}}},
                                        cur_hits_reg, cur_ratio_reg,
                                        total_reg, rsp_reg.tick_count};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;
endmodule
`default_nettype wire

// ===== rtl/pshst_div.sv =====
`default_nettype none
module pshst_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [31:0]                      hits,
    input  wire logic [31:0]                      divisor,
    output logic                                  done,
    output logic [pshst_pkg::DIVIDEND_W-1:0]      quotient
);
    import pshst_pkg::*;

    logic [31:0]            rem_reg;
    logic [DIVIDEND_W-1:0]  sh_reg;
    logic [31:0]            div_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   done_reg;
    logic [32:0]            trial;
    logic                   ge;
    logic [32:0]            diff;

    assign trial = {rem_reg, sh_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= '0;
                sh_reg  <= {hits, {RATIO_SHIFT{1'b0}}};
                div_reg <= divisor;
                cnt_reg <= DIV_CNT_W'(DIVIDEND_W);
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? diff[31:0] : trial[31:0];
                sh_reg  <= {sh_reg[DIVIDEND_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;
endmodule
`default_nettype wire

// ===== dv/pc_sample_hot_spot_table_core_tb.sv =====
`default_nettype none
module pc_sample_hot_spot_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pshst_pkg::*;

    localparam logic [1:0] REQ_BAD = 2'd3;

    class hot_spot_scoreboard;
        logic [7:0]  prescale_div;
        logic [31:0] ignore_base;
        logic [7:0]  prescale_cnt;
        logic [31:0] tick_cnt;
        logic [4:0]  decay_pos;
        logic [31:0] total;
        logic [31:0] base_tbl [TABLE_ENTRIES];
        logic [31:0] hits_tbl [TABLE_ENTRIES];
        logic [10:0] ratio_tbl [TABLE_ENTRIES];
        rsp_t        pending_q [$];
        int          errors;

        function new();
            prescale_div = 8'd10;
            ignore_base = '0;
            prescale_cnt = '0;
            tick_cnt = '0;
            errors = 0;
            wipe_table();
        endfunction

        function void wipe_table();
            decay_pos = '0;
            total = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                base_tbl[i] = '0;
                hits_tbl[i] = '0;
                ratio_tbl[i] = '0;
            end
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == CFG_PRESCALE) prescale_div = val[7:0];
            else ignore_base = val;
        endfunction

        function int bump_entry(int pos, logic [31:0] pc);
            logic [63:0] q;
            logic [31:0] tb, th;
            logic [10:0] tr;
            base_tbl[pos] = {pc[31:4], 4'h0};
            total = total + HIT_INC;
            hits_tbl[pos] = hits_tbl[pos] + HIT_INC;
            if (total == 0) begin
                q = 64'd1024;
            end else begin
                q = {hits_tbl[pos], 10'd0} / {32'd0, total};
                if (q > 64'd1024) q = 64'd1024;
            end
            ratio_tbl[pos] = q[10:0];
            while (pos > 0 && hits_tbl[pos] > hits_tbl[pos-1]) begin
                tb = base_tbl[pos]; th = hits_tbl[pos]; tr = ratio_tbl[pos];
                base_tbl[pos] = base_tbl[pos-1];
                hits_tbl[pos] = hits_tbl[pos-1];
                ratio_tbl[pos] = ratio_tbl[pos-1];
                base_tbl[pos-1] = tb; hits_tbl[pos-1] = th; ratio_tbl[pos-1] = tr;
                pos--;
            end
            return pos;
        endfunction

        function int profile_pc(logic [31:0] pc);
            int d, free_pos;
            logic [31:0] key;
            key = {pc[31:4], 4'h0};
            free_pos = TABLE_ENTRIES;
            d = decay_pos;
            if (d >= TABLE_ENTRIES) d = 0;
            if (hits_tbl[d] > 1) begin
                hits_tbl[d] = hits_tbl[d] - 1;
                total = total - 1;
            end
            d++;
            if (d >= TABLE_ENTRIES) d = 0;
            decay_pos = d[4:0];
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (base_tbl[i] == key) return bump_entry(i, pc);
                if (free_pos == TABLE_ENTRIES && hits_tbl[i] == 0) free_pos = i;
            end
            if (free_pos < TABLE_ENTRIES) return bump_entry(free_pos, pc);
            total = total - hits_tbl[TABLE_ENTRIES-1];
            hits_tbl[TABLE_ENTRIES-1] = '0;
            return bump_entry(TABLE_ENTRIES - 1, pc);
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int s;
            logic [31:0] off;
            e = '0;
            if (r.req_type == REQ_TICK) begin
                prescale_cnt = prescale_cnt + 8'd1;
                if (prescale_cnt >= prescale_div) begin
                    prescale_cnt = '0;
                    e.sampled = 1'b1;
                    off = r.sample_pc - ignore_base;
                    if (off < GRAN_BYTES) begin
                        e.ignored = 1'b1;
                    end else begin
                        s = profile_pc(r.sample_pc);
                        e.slot = s[4:0];
                        e.entry_base = base_tbl[s];
                        e.entry_hits = hits_tbl[s];
                        e.entry_ratio = ratio_tbl[s];
                    end
                    tick_cnt = tick_cnt + 1;
                end
            end else if (r.req_type == REQ_READ) begin
                e.slot = r.entry_index;
                if (r.entry_index < TABLE_ENTRIES) begin
                    e.entry_base = base_tbl[r.entry_index];
                    e.entry_hits = hits_tbl[r.entry_index];
                    e.entry_ratio = ratio_tbl[r.entry_index];
                end
            end else if (r.req_type == REQ_CLEAR) begin
                wipe_table();
            end
            e.total_hits = total;
            e.tick_count = tick_cnt;
            pending_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.sampled !== e.sampled)
                $display("%0t: sampled exp %h got %h", $time, e.sampled, got.sampled);
            if (got.ignored !== e.ignored)
                $display("%0t: ignored exp %h got %h", $time, e.ignored, got.ignored);
            if (got.slot !== e.slot)
                $display("%0t: slot exp %0d got %0d", $time, e.slot, got.slot);
            if (got.entry_base !== e.entry_base)
                $display("%0t: entry_base exp %h got %h", $time, e.entry_base,
                         got.entry_base);
            if (got.entry_hits !== e.entry_hits)
                $display("%0t: entry_hits exp %h got %h", $time, e.entry_hits,
                         got.entry_hits);
            if (got.entry_ratio !== e.entry_ratio)
                $display("%0t: entry_ratio exp %0d got %0d", $time, e.entry_ratio,
                         got.entry_ratio);
            if (got.total_hits !== e.total_hits)
                $display("%0t: total_hits exp %h got %h", $time, e.total_hits,
                         got.total_hits);
            if (got.tick_count !== e.tick_count)
                $display("%0t: tick_count exp %h got %h", $time, e.tick_count,
                         got.tick_count);
            if (got !== e) errors++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready;
    rsp_t        m_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    hot_spot_scoreboard sb;
    logic [31:0] hot_pcs [8];
    logic [31:0] cur_ignore;

    pc_sample_hot_spot_table_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0; #4;
        aclk = 1'b1; #4;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(logic [1:0] rt, logic [31:0] pc, logic [4:0] idx);
        req_t r;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        r.req_type = rt;
        r.sample_pc = pc;
        r.entry_index = idx;
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        if (idx == CFG_IGNORE) cur_ignore = val;
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int k;
        logic [31:0] pc;
        k = $urandom_range(0, 99);
        if (k < 70) begin
            pc = ($urandom_range(0, 2) == 0) ? $urandom() :
                 hot_pcs[$urandom_range(0, 7)] + $urandom_range(0, 15);
            send_word(REQ_TICK, pc, 5'($urandom()));
        end else if (k < 76) begin
            send_word(REQ_TICK, cur_ignore + $urandom_range(0, 17), 5'($urandom()));
        end else if (k < 93) begin
            send_word(REQ_READ, $urandom(), 5'($urandom_range(0, 31)));
        end else if (k < 95) begin
            send_word(REQ_CLEAR, $urandom(), 5'($urandom()));
        end else begin
            send_word(REQ_BAD, $urandom(), 5'($urandom()));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end else if (!m_ready) begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int wait_cnt;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_PRESCALE;
        cfg_wdata = '0;
        cur_ignore = '0;
        for (int i = 0; i < 8; i++) hot_pcs[i] = $urandom() & 32'hFFFF_FFF0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_PRESCALE, 32'd1);
        write_reg(CFG_IGNORE, 32'hFFFF_FFF8);
        send_word(REQ_TICK, 32'hFFFF_FFFF, 5'd31);
        send_word(REQ_TICK, 32'h0000_0007, 5'd0);
        send_word(REQ_TICK, 32'h0000_0008, 5'd0);
        send_word(REQ_TICK, 32'hFFFF_FFF7, 5'd0);
        send_word(REQ_TICK, 32'h0000_0000, 5'd0);
        send_word(REQ_TICK, 32'h1234_5678, 5'd0);
        send_word(REQ_TICK, 32'h1234_5670, 5'd0);
        for (int i = 0; i < 22; i++) send_word(REQ_TICK, 32'h100 * (i + 1), 5'd0);
        send_word(REQ_READ, 32'hFFFF_FFFF, 5'd0);
        send_word(REQ_READ, 32'h0, 5'd19);
        send_word(REQ_READ, 32'h0, 5'd20);
        send_word(REQ_READ, 32'h0, 5'd31);
        send_word(REQ_BAD, 32'hA5A5_A5A5, 5'd7);
        send_word(REQ_CLEAR, 32'h0, 5'd0);
        send_word(REQ_READ, 32'h0, 5'd0);

        write_reg(CFG_PRESCALE, 32'd0);
        write_reg(CFG_IGNORE, 32'h0000_0000);
        repeat (300) random_word();
        write_reg(CFG_PRESCALE, 32'd255);
        write_reg(CFG_IGNORE, 32'hFFFF_FFFF);
        repeat (300) send_word(REQ_TICK, $urandom(), 5'($urandom()));
        write_reg(CFG_PRESCALE, 32'd3);
        write_reg(CFG_IGNORE, hot_pcs[0]);
        repeat (350) random_word();
        write_reg(CFG_PRESCALE, 32'd1);
        write_reg(CFG_IGNORE, $urandom());
        repeat (300) random_word();
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
